[rtl/fdpd_pkg.sv]
// Shared types, codes and arithmetic constants for the frontlight duty block.
package fdpd_pkg;

	// Command codes carried in each request.
	typedef enum logic [1:0] {
		CMD_SET_LEVEL = 2'd0,
		CMD_SET_WARM  = 2'd1,
		CMD_OFF       = 2'd2,
		CMD_ON        = 2'd3
	} fdpd_cmd_t;

	// Output mode codes.
	typedef enum logic [1:0] {
		MODE_NONE   = 2'd0,
		MODE_PMIC   = 2'd1,
		MODE_SINGLE = 2'd2,
		MODE_DUAL   = 2'd3
	} fdpd_mode_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_OUTPUT_MODE     = 2'd0;
	localparam logic [1:0] REG_RESOLUTION_BITS = 2'd1;
	localparam logic [1:0] REG_ACTIVE_HIGH     = 2'd2;
	localparam int unsigned CFG_DATA_W = 5;

	// Percent limits and rounding constants.
	localparam logic [6:0]  PCT_MAX      = 7'd100;
	localparam logic [6:0]  PCT_LAST_RST = 7'd100;
	localparam logic [11:0] PMIC_SCALE   = 12'd4095;
	localparam logic [5:0]  ROUND_HALF   = 6'd50;
	localparam logic [4:0]  RES_BITS_MAX = 5'd16;

	// Exact floor(x / 100) for x below 2^30: (x * DIV100_MUL) >> DIV100_SHIFT.
	localparam int unsigned DIV_IN_W     = 30;
	localparam int unsigned DIV_MUL_W    = 31;
	localparam int unsigned DIV_PROD_W   = DIV_IN_W + DIV_MUL_W;
	localparam int unsigned DIV100_SHIFT = 37;
	localparam logic [DIV_MUL_W-1:0] DIV100_MUL = 31'd1374389535;
	localparam int unsigned DIV_QUOT_W   = DIV_PROD_W - DIV100_SHIFT;

	// One request as it arrives.
	typedef struct packed {
		fdpd_cmd_t   cmd;
		logic [7:0]  value;
	} fdpd_in_t;

	// One result as it leaves.
	typedef struct packed {
		logic [15:0] cool_duty;
		logic [15:0] warm_duty;
		logic        cool_write;
		logic        warm_write;
		logic [7:0]  pmic_low_byte;
		logic [4:0]  pmic_high_byte;
		logic        pmic_write;
		logic [6:0]  level_now;
	} fdpd_out_t;

	// Job handed from the front end to the duty engine.
	typedef struct packed {
		logic [6:0] level;
		logic [6:0] warm;
	} fdpd_job_t;

	// Configuration seen by the duty engine.
	typedef struct packed {
		fdpd_mode_t mode;
		logic [4:0] res_bits;
		logic       active_high;
	} fdpd_cfg_t;

endpackage

[rtl/fdpd_front.sv]
// Command front end: clamps arguments, updates the light state and emits jobs.
module fdpd_front
	import fdpd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  fdpd_in_t  request,
	input  logic      job_full,
	output logic      job_push,
	output fdpd_job_t job
);

	logic [6:0] level_q;
	logic [6:0] last_q;
	logic [6:0] warm_q;
	logic [6:0] arg;
	logic [6:0] level_nxt;
	logic [6:0] last_nxt;
	logic [6:0] warm_nxt;

	// Percent argument saturates at full brightness.
	assign arg = (request.value > {1'b0, PCT_MAX}) ? PCT_MAX : request.value[6:0];

	// Next state for the accepted command.
	always_comb begin
		level_nxt = level_q;
		last_nxt  = last_q;
		warm_nxt  = warm_q;
		unique case (request.cmd)
			CMD_SET_LEVEL: level_nxt = arg;
			CMD_SET_WARM:  warm_nxt  = arg;
			CMD_OFF:       level_nxt = 7'd0;
			CMD_ON:        level_nxt = last_q;
			default:       level_nxt = level_q;
		endcase
		if (level_nxt != 7'd0) begin
			last_nxt = level_nxt;
		end
	end

	assign job_push  = push && !job_full;
	assign job.level = level_nxt;
	assign job.warm  = warm_nxt;

	// Light state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 7'd0;
			last_q  <= PCT_LAST_RST;
			warm_q  <= 7'd0;
		end else if (job_push) begin
			level_q <= level_nxt;
			last_q  <= last_nxt;
			warm_q  <= warm_nxt;
		end
	end

endmodule

[rtl/fdpd_fifo.sv]
// Short job queue between the front end and the duty engine.
module fdpd_fifo
	import fdpd_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  fdpd_job_t wr_data,
	output logic      full,
	input  logic      rd_en,
	output fdpd_job_t rd_data,
	output logic      empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	fdpd_job_t     slots_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slots_q[rd_ptr_q];

	// Storage slots.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

[rtl/fdpd_engine.sv]
// Duty engine: sequences the multiplies and constant divides for one job.
module fdpd_engine
	import fdpd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  fdpd_cfg_t cfg,
	input  logic      job_empty,
	input  fdpd_job_t job,
	output logic      job_pop,
	input  logic      pop,
	output logic      empty,
	output fdpd_out_t result
);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_SQ   = 10'b00_0000_0010,
		ST_DLIN = 10'b00_0000_0100,
		ST_X    = 10'b00_0000_1000,
		ST_D1   = 10'b00_0001_0000,
		ST_D2   = 10'b00_0010_0000,
		ST_E    = 10'b00_0100_0000,
		ST_W    = 10'b00_1000_0000,
		ST_DW   = 10'b01_0000_0000,
		ST_DONE = 10'b10_0000_0000
	} fdpd_state_t;

	fdpd_state_t             state_q;
	logic [6:0]              lvl_q;
	logic [6:0]              wrm_q;
	logic [13:0]             sq_q;
	logic [DIV_IN_W-1:0]     num_q;
	logic [DIV_PROD_W-1:0]   prod_q;
	logic [15:0]             lin_q;
	logic [11:0]             pmic_q;
	logic [15:0]             e_q;
	fdpd_out_t               res_q;
	logic                    res_valid_q;

	logic [DIV_QUOT_W-1:0]   quot;
	logic [15:0]             full;
	logic [16:0]             e_sum;
	logic [15:0]             e_nxt;
	logic [15:0]             warm_e;
	logic [15:0]             cool_e;
	logic                    mix;
	logic                    res_take;
	fdpd_out_t               res_nxt;

	// Quotient of the registered reciprocal product.
	assign quot = prod_q[DIV_PROD_W-1:DIV100_SHIFT];

	// Full-scale duty from the resolution register.
	always_comb begin
		if (cfg.res_bits >= RES_BITS_MAX) begin
			full = 16'hFFFF;
		end else begin
			full = 16'((17'd1 << cfg.res_bits[3:0]) - 17'd1);
		end
	end

	// Energy: average of the linear and square terms; zero at level 0, else floored at 1 and capped at full.
	always_comb begin
		e_sum = {1'b0, lin_q} + {1'b0, quot[15:0]};
		e_nxt = e_sum[16:1];
		if (lvl_q == 7'd0) begin
			e_nxt = 16'd0;
		end else begin
			if (e_nxt == 16'd0) begin
				e_nxt = 16'd1;
			end
			if (e_nxt > full) begin
				e_nxt = full;
			end
		end
	end

	// Warm and cool split of the energy with one-count floors in the interior mix.
	always_comb begin
		warm_e = (quot > {{(DIV_QUOT_W-16){1'b0}}, e_q}) ? e_q : quot[15:0];
		cool_e = e_q - warm_e;
		mix    = (lvl_q != 7'd0) && (wrm_q != 7'd0) && (wrm_q < PCT_MAX) && (e_q >= 16'd2);
		if (mix) begin
			if (cool_e == 16'd0) begin
				cool_e = 16'd1;
				warm_e = e_q - 16'd1;
			end else if (warm_e == 16'd0) begin
				warm_e = 16'd1;
				cool_e = e_q - 16'd1;
			end
		end
	end

	// Result fields for the selected mode.
	always_comb begin
		res_nxt = '0;
		res_nxt.level_now = lvl_q;
		unique case (cfg.mode)
			MODE_NONE: begin
			end
			MODE_PMIC: begin
				res_nxt.pmic_low_byte  = pmic_q[7:0];
				res_nxt.pmic_high_byte = {(pmic_q != 12'd0), pmic_q[11:8]};
				res_nxt.pmic_write     = 1'b1;
			end
			MODE_SINGLE: begin
				res_nxt.cool_duty  = cfg.active_high ? e_q : full - e_q;
				res_nxt.cool_write = 1'b1;
			end
			MODE_DUAL: begin
				res_nxt.cool_duty  = cfg.active_high ? cool_e : full - cool_e;
				res_nxt.warm_duty  = cfg.active_high ? warm_e : full - warm_e;
				res_nxt.cool_write = 1'b1;
				res_nxt.warm_write = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign job_pop  = (state_q == ST_IDLE) && !job_empty;
	assign res_take = (state_q == ST_DONE) && (!res_valid_q || pop);
	assign empty    = !res_valid_q;
	assign result   = res_q;

	// Datapath registers, loaded step by step by the sequencer.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				lvl_q <= job.level;
				wrm_q <= job.warm;
			end
			ST_SQ: begin
				sq_q  <= lvl_q * lvl_q;
				num_q <= DIV_IN_W'(lvl_q) * DIV_IN_W'(full);
			end
			ST_DLIN: prod_q <= num_q * DIV100_MUL;
			ST_X: begin
				lin_q <= quot[15:0];
				if (cfg.mode == MODE_PMIC) begin
					num_q <= DIV_IN_W'(sq_q) * DIV_IN_W'(PMIC_SCALE);
				end else begin
					num_q <= DIV_IN_W'(sq_q) * DIV_IN_W'(full);
				end
			end
			ST_D1: prod_q <= num_q * DIV100_MUL;
			ST_D2: prod_q <= DIV_IN_W'(quot) * DIV100_MUL;
			ST_E: begin
				pmic_q <= quot[11:0];
				e_q    <= e_nxt;
			end
			ST_W: num_q <= DIV_IN_W'(e_q) * DIV_IN_W'(wrm_q) + DIV_IN_W'(ROUND_HALF);
			ST_DW: prod_q <= num_q * DIV100_MUL;
			ST_DONE: begin
				if (res_take) begin
					res_q <= res_nxt;
				end
			end
			default: begin
			end
		endcase
	end

	// Step sequencer and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (!job_empty) state_q <= ST_SQ;
				ST_SQ:   state_q <= ST_DLIN;
				ST_DLIN: state_q <= ST_X;
				ST_X:    state_q <= ST_D1;
				ST_D1:   state_q <= ST_D2;
				ST_D2:   state_q <= ST_E;
				ST_E:    state_q <= ST_W;
				ST_W:    state_q <= ST_DW;
				ST_DW:   state_q <= ST_DONE;
				ST_DONE: if (res_take) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (res_take) begin
				res_valid_q <= 1'b1;
			end else if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/frontlight_dual_pwm_duty_core.sv]
// Top level of the frontlight duty block: config registers, front end, job queue, engine.
//
//  channel  | handshake        | payload
//  ---------+------------------+-------------------------
//  request  | push / full      | request (fdpd_in_t)
//  result   | empty / pop      | result (fdpd_out_t)
//  config   | cfg_we           | cfg_idx, cfg_data
//
// In the duty engine each request passes through one step to pick up the job, eight
// sequenced multiply, reciprocal-divide and clamp steps, and one to load the result register.
// The front end takes a request every cycle while the job queue has room.
// Reset clears the light state to level 0, last level 100, warm share 0, and the
// config to mode none, 8-bit resolution, active high.
// A result not popped holds the engine in its last step; the queue then fills and raises full.
module frontlight_dual_pwm_duty_core
	import fdpd_pkg::*;
#(
	parameter int unsigned JOB_DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  fdpd_in_t              request,
	output logic                  empty,
	input  logic                  pop,
	output fdpd_out_t             result,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	fdpd_cfg_t cfg_q;
	logic      job_push;
	fdpd_job_t job_in;
	logic      job_full;
	logic      job_pop;
	fdpd_job_t job_out;
	logic      job_empty;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode        <= MODE_NONE;
			cfg_q.res_bits    <= 5'd8;
			cfg_q.active_high <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_OUTPUT_MODE:     cfg_q.mode        <= fdpd_mode_t'(cfg_data[1:0]);
				REG_RESOLUTION_BITS: cfg_q.res_bits    <= cfg_data[4:0];
				REG_ACTIVE_HIGH:     cfg_q.active_high <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign full = job_full;

	fdpd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.request  (request),
		.job_full (job_full),
		.job_push (job_push),
		.job      (job_in)
	);

	fdpd_fifo #(
		.DEPTH (JOB_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_data (job_in),
		.full    (job_full),
		.rd_en   (job_pop),
		.rd_data (job_out),
		.empty   (job_empty)
	);

	fdpd_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_empty (job_empty),
		.job       (job_out),
		.job_pop   (job_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

[rtl/fdpd_checker.sv]
// Port-level checks for the frontlight duty block, bound to the top level.
module fdpd_checker
	import fdpd_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  push,
	input logic                  full,
	input fdpd_in_t              request,
	input logic                  empty,
	input logic                  pop,
	input fdpd_out_t             result,
	input logic                  cfg_we,
	input logic [1:0]            cfg_idx,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	// A waiting result holds until it is popped.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed or vanished before pop");

	// The warm channel is only ever driven together with the cool channel.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.warm_write |-> result.cool_write && !result.pmic_write)
		else $error("warm channel driven without cool channel");

	// PMIC enable bit follows a nonzero duty.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.pmic_write |->
		result.pmic_high_byte[4] ==
		((result.pmic_low_byte != 8'd0) || (result.pmic_high_byte[3:0] != 4'd0)))
		else $error("PMIC enable bit does not match duty");

	// A dark light writes a zero PMIC duty.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (result.level_now == 7'd0) |->
		(result.pmic_low_byte == 8'd0) && (result.pmic_high_byte == 5'd0))
		else $error("nonzero PMIC duty at level zero");

endmodule

bind frontlight_dual_pwm_duty_core fdpd_checker u_fdpd_checker (.*);

[tb/fdpd_drive_checker.sv]
// Checker for the frontlight duty block: tracks config and light state, predicts and compares.
`timescale 1ns / 100ps

module fdpd_drive_checker
	import fdpd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic                  full,
	input  fdpd_in_t              request,
	input  logic                  empty,
	input  logic                  pop,
	input  fdpd_out_t             result,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int unsigned           mismatches,
	output int unsigned           pending
);

	localparam int unsigned REPORT_LIMIT = 10;

	// Drive values still owed by the block, oldest first.
	fdpd_out_t drive_expected[$];

	// Shadow copies of the config registers and the light state.
	fdpd_mode_t mode_q;
	logic [4:0] res_q;
	logic       active_high_q;
	logic [6:0] level_q;
	logic [6:0] last_level_q;
	logic [6:0] warm_q;
	int unsigned bad_count;

	// Light energy for a brightness: mean of a linear and a square term; zero at 0, else floored at 1 and capped at full.
	function automatic int unsigned scaled_energy(input int unsigned pct, input int unsigned fs);
		int unsigned lin;
		int unsigned sq;
		int unsigned e;
		if (pct == 0)
			return 0;
		lin = pct * fs / 100;
		sq = pct * pct * fs / 10000;
		e = (lin + sq) / 2;
		if (e < 1)
			e = 1;
		if (e > fs)
			e = fs;
		return e;
	endfunction

	// Pin duty for an energy, inverted when the output is active low.
	function automatic int unsigned pin_level(input int unsigned e, input int unsigned fs,
			input logic ah);
		if (e > fs)
			e = fs;
		return ah ? e : fs - e;
	endfunction

	// Full drive result for the current brightness, warm share and config.
	function automatic fdpd_out_t predict_drive(input logic [6:0] lvl, input logic [6:0] wp,
			input fdpd_mode_t mode, input logic [4:0] res, input logic ah);
		fdpd_out_t r;
		int unsigned pct;
		int unsigned share;
		int unsigned fs;
		int unsigned d12;
		int unsigned tot;
		int unsigned warm;
		int unsigned cool;
		r = '0;
		r.level_now = lvl;
		pct = lvl;
		share = wp;
		fs = (res > RES_BITS_MAX) ? 32'hFFFF : (32'd1 << res) - 1;
		case (mode)
			MODE_PMIC: begin
				d12 = pct * pct * 4095 / 10000;
				r.pmic_low_byte = d12[7:0];
				r.pmic_high_byte = {d12 != 0, d12[11:8]};
				r.pmic_write = 1'b1;
			end
			MODE_SINGLE: begin
				r.cool_duty = 16'(pin_level(scaled_energy(pct, fs), fs, ah));
				r.cool_write = 1'b1;
			end
			MODE_DUAL: begin
				tot = scaled_energy(pct, fs);
				warm = (tot * share + 50) / 100;
				if (warm > tot)
					warm = tot;
				cool = tot - warm;
				// A mixed share keeps at least one count on each channel.
				if (pct != 0 && share != 0 && share < 100 && tot >= 2) begin
					if (cool == 0) begin
						cool = 1;
						warm = tot - 1;
					end else if (warm == 0) begin
						warm = 1;
						cool = tot - 1;
					end
				end
				r.cool_duty = 16'(pin_level(cool, fs, ah));
				r.warm_duty = 16'(pin_level(warm, fs, ah));
				r.cool_write = 1'b1;
				r.warm_write = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	// Watch config writes, requests and results at every clock edge.
	always @(posedge clk or negedge arst_n) begin : watch
		fdpd_out_t want;
		logic [6:0] pct;
		if (!arst_n) begin
			mode_q = MODE_NONE;
			res_q = 5'd8;
			active_high_q = 1'b1;
			level_q = '0;
			last_level_q = PCT_LAST_RST;
			warm_q = '0;
			drive_expected.delete();
			bad_count = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_OUTPUT_MODE:     mode_q = fdpd_mode_t'(cfg_data[1:0]);
					REG_RESOLUTION_BITS: res_q = cfg_data[4:0];
					REG_ACTIVE_HIGH:     active_high_q = cfg_data[0];
					default: ;
				endcase
			end

			// An accepted request updates the light state and owes one result.
			if (push && !full) begin
				pct = (request.value > PCT_MAX) ? PCT_MAX : request.value[6:0];
				if (request.cmd == CMD_SET_WARM) begin
					warm_q = pct;
				end else begin
					case (request.cmd)
						CMD_SET_LEVEL: level_q = pct;
						CMD_OFF:       level_q = '0;
						default:       level_q = last_level_q;
					endcase
					if (level_q != 0)
						last_level_q = level_q;
				end
				drive_expected.push_back(predict_drive(level_q, warm_q, mode_q, res_q,
					active_high_q));
			end

			// An accepted result must match the oldest prediction.
			if (pop && !empty) begin
				if (drive_expected.size() == 0) begin
					bad_count++;
					if (bad_count <= REPORT_LIMIT)
						$display("%0t: result with no request outstanding", $realtime);
				end else begin
					want = drive_expected.pop_front();
					if (result.cool_duty != want.cool_duty || result.warm_duty != want.warm_duty
							|| result.cool_write != want.cool_write
							|| result.warm_write != want.warm_write
							|| result.pmic_low_byte != want.pmic_low_byte
							|| result.pmic_high_byte != want.pmic_high_byte
							|| result.pmic_write != want.pmic_write
							|| result.level_now != want.level_now) begin
						bad_count++;
						if (bad_count <= REPORT_LIMIT) begin
							$display("%0t: drive mismatch, expected cool %0d warm %0d wr %b%b pmic %h %h wr %b level %0d",
								$realtime, want.cool_duty, want.warm_duty, want.cool_write,
								want.warm_write, want.pmic_low_byte, want.pmic_high_byte,
								want.pmic_write, want.level_now);
							$display("%0t: drive mismatch, actual   cool %0d warm %0d wr %b%b pmic %h %h wr %b level %0d",
								$realtime, result.cool_duty, result.warm_duty, result.cool_write,
								result.warm_write, result.pmic_low_byte, result.pmic_high_byte,
								result.pmic_write, result.level_now);
						end
					end
				end
			end

			mismatches <= bad_count;
			pending <= drive_expected.size();
		end
	end

endmodule

[tb/tb_frontlight_dual_pwm_duty_core.sv]
// Testbench top for the frontlight duty block: clock, reset, requests, config phases, verdict.
`timescale 1ns / 100ps

module tb_frontlight_dual_pwm_duty_core;
	import fdpd_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned PHASES        = 14;
	localparam int unsigned PHASE_ITEMS   = 50;
	localparam int unsigned SETTLE_CYCLES = 30;
	localparam int unsigned MAX_GAP       = 13;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	fdpd_in_t              request = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	fdpd_out_t             result;
	logic                  cfg_we = 1'b0;
	logic [1:0]            cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int unsigned mismatches;
	int unsigned pending;
	int unsigned cycles = 0;
	bit          source_calm = 1'b0;
	bit          sink_calm = 1'b0;

	frontlight_dual_pwm_duty_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.request  (request),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	fdpd_drive_checker i_drive_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.request    (request),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Random percent argument: mostly in range, some above 100, some corner values.
	function automatic logic [7:0] random_percent();
		int unsigned pick;
		pick = $urandom_range(0, 19);
		if (pick < 14)
			return 8'($urandom_range(0, 100));
		if (pick < 17)
			return 8'($urandom_range(101, 255));
		case ($urandom_range(0, 4))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd99;
			3: return 8'd100;
			default: return 8'd255;
		endcase
	endfunction

	// Random command, weighted toward brightness changes.
	function automatic fdpd_cmd_t random_cmd();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			return CMD_SET_LEVEL;
		if (pick < 7)
			return CMD_SET_WARM;
		if (pick < 8)
			return CMD_OFF;
		return CMD_ON;
	endfunction

	// Send one request after a random gap; push stays high when no gap follows.
	task automatic send_request(input fdpd_cmd_t c, input logic [7:0] v);
		int unsigned gap;
		if ($urandom_range(0, 29) == 0)
			source_calm = !source_calm;
		gap = source_calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		request <= '{cmd: c, value: v};
		do @(posedge clk); while (full);
	endtask

	// Stop sending and wait until every result is back and the engine is quiet.
	task automatic settle();
		push <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all three config registers on consecutive cycles.
	task automatic write_config(input fdpd_mode_t mode, input logic [4:0] res, input logic ah);
		cfg_we <= 1'b1;
		cfg_idx <= REG_OUTPUT_MODE;
		cfg_data <= CFG_DATA_W'(mode);
		@(posedge clk);
		cfg_idx <= REG_RESOLUTION_BITS;
		cfg_data <= res;
		@(posedge clk);
		cfg_idx <= REG_ACTIVE_HIGH;
		cfg_data <= CFG_DATA_W'(ah);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Directed requests: clamps, endpoints, mixed-share floors, on/off and each mode.
	task automatic run_directed();
		// Reset config: no output, on restores the reset last level.
		send_request(CMD_ON, 8'd0);
		send_request(CMD_SET_LEVEL, 8'd255);
		settle();

		write_config(MODE_DUAL, 5'd8, 1'b1);
		send_request(CMD_SET_WARM, 8'd1);
		send_request(CMD_SET_LEVEL, 8'd2);    // warm rounds to zero, gets one count
		send_request(CMD_SET_WARM, 8'd99);    // cool rounds to zero, gets one count
		send_request(CMD_SET_WARM, 8'd0);
		send_request(CMD_SET_WARM, 8'd100);
		send_request(CMD_SET_WARM, 8'd200);
		send_request(CMD_SET_WARM, 8'd50);
		send_request(CMD_SET_LEVEL, 8'd1);
		send_request(CMD_SET_LEVEL, 8'd100);
		send_request(CMD_SET_LEVEL, 8'd101);
		send_request(CMD_SET_LEVEL, 8'd0);
		send_request(CMD_ON, 8'd255);
		send_request(CMD_OFF, 8'd77);
		send_request(CMD_ON, 8'd0);
		send_request(CMD_SET_LEVEL, 8'd128);
		send_request(CMD_SET_WARM, 8'd255);
		settle();

		write_config(MODE_PMIC, 5'd8, 1'b1);
		send_request(CMD_SET_LEVEL, 8'd100);
		send_request(CMD_SET_LEVEL, 8'd1);
		send_request(CMD_SET_LEVEL, 8'd2);
		settle();

		write_config(MODE_SINGLE, 5'd16, 1'b0);
		send_request(CMD_SET_LEVEL, 8'd1);
		send_request(CMD_SET_LEVEL, 8'd100);
		settle();

		write_config(MODE_SINGLE, 5'd0, 1'b1);
		send_request(CMD_SET_LEVEL, 8'd50);
		settle();
	endtask

	// Result side: random stalls with calm stretches.
	initial begin : result_sink
		int unsigned stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0)
				sink_calm = !sink_calm;
			stall = sink_calm ? 0 : $urandom_range(0, MAX_GAP);
			if (stall != 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	// Request side: reset, directed part, then random phases over several configs.
	initial begin : stimulus
		fdpd_mode_t  mode;
		logic [4:0]  res;
		logic        ah;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		for (int p = 0; p < PHASES; p++) begin
			mode = fdpd_mode_t'(p % 4);
			case (p % 7)
				0: res = 5'd1;
				1: res = 5'd16;
				2: res = 5'd0;
				3: res = 5'd31;
				4: res = 5'd8;
				default: res = 5'($urandom_range(2, 15));
			endcase
			ah = (p % 3 != 0);
			write_config(mode, res, ah);
			repeat (PHASE_ITEMS) begin
				send_request(random_cmd(), random_percent());
				// Now and then hold off until the block has drained.
				if ($urandom_range(0, 99) == 0)
					settle();
			end
			settle();
		end

		if (mismatches == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[frontlight_dual_pwm_duty_core.f]
rtl/fdpd_pkg.sv
rtl/fdpd_front.sv
rtl/fdpd_fifo.sv
rtl/fdpd_engine.sv
rtl/frontlight_dual_pwm_duty_core.sv
rtl/fdpd_checker.sv
tb/fdpd_drive_checker.sv
tb/tb_frontlight_dual_pwm_duty_core.sv
